/* design/s2i_pkg.sv */
`default_nettype none
package s2i_pkg;

  // Parse phases.
  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_SPACE  = 3'd1;
  localparam logic [2:0] PH_LEAD   = 3'd2;
  localparam logic [2:0] PH_ZERO   = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  localparam int unsigned CH_BITS     = 8;
  localparam int unsigned BASE_BITS   = 6;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned OFFSET_W    = 16;

  localparam logic [BASE_BITS-1:0] BASE_RESET = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_DETECT = 6'd0;
  localparam logic [BASE_BITS-1:0] BASE_OCT = 6'd8;
  localparam logic [BASE_BITS-1:0] BASE_DEC = 6'd10;
  localparam logic [BASE_BITS-1:0] BASE_HEX = 6'd16;
  localparam logic [BASE_BITS-1:0] DIGIT_NONE = 6'h3F;

  localparam logic [CH_BITS-1:0] CH_ZERO  = 8'h30;
  localparam logic [CH_BITS-1:0] CH_NINE  = 8'h39;
  localparam logic [CH_BITS-1:0] CH_LO_A  = 8'h61;
  localparam logic [CH_BITS-1:0] CH_LO_Z  = 8'h7A;
  localparam logic [CH_BITS-1:0] CH_UP_A  = 8'h41;
  localparam logic [CH_BITS-1:0] CH_UP_Z  = 8'h5A;
  localparam logic [CH_BITS-1:0] CH_LO_X  = 8'h78;
  localparam logic [CH_BITS-1:0] CH_UP_X  = 8'h58;
  localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2D;
  localparam logic [CH_BITS-1:0] CH_SP    = 8'h20;
  localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
  localparam logic [CH_BITS-1:0] CH_LF    = 8'h0A;
  localparam logic [CH_BITS-1:0] CH_VT    = 8'h0B;
  localparam logic [CH_BITS-1:0] CH_FF    = 8'h0C;
  localparam logic [CH_BITS-1:0] CH_CR    = 8'h0D;
  localparam logic [CH_BITS-1:0] LETTER_OFS = 8'd10;

  typedef struct packed {
    logic [CH_BITS-1:0] ch;
    logic               start_req;
  } item_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   value;
    logic [OFFSET_W-1:0]  end_offset;
    logic [BASE_BITS-1:0] base_used;
  } result_t;

  function automatic logic [BASE_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
    logic [BASE_BITS-1:0] d;
    begin
      d = DIGIT_NONE;
      if (c >= CH_ZERO && c <= CH_NINE) begin
        d = BASE_BITS'(c - CH_ZERO);
      end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
        d = BASE_BITS'(c - CH_LO_A + LETTER_OFS);
      end else if (c >= CH_UP_A && c <= CH_UP_Z) begin
        d = BASE_BITS'(c - CH_UP_A + LETTER_OFS);
      end
      return d;
    end
  endfunction

  function automatic logic is_space(input logic [CH_BITS-1:0] c);
    return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_VT) ||
           (c == CH_FF) || (c == CH_CR);
  endfunction

endpackage
`default_nettype wire

/* design/string_to_integer_parser_core.sv */
`default_nettype none
// Channel  Direction  Handshake             Payload
// in_      input      in_valid / in_stall   in_ch, in_start_req
// out_     output     out_valid / out_stall out_value, out_end_offset, out_base_used
// cfg_     input      cfg_valid / cfg_ready cfg_base_setting
//
// One character is taken per cycle unless the input is stalled; the character that ends
// the parse passes the input register, then the result register presents the result.
// The throughput is set by the accumulator update, one multiply-add per unstalled cycle.
// Reset is synchronous and active low; the base register returns to ten.
// A refused result holds the parse stage, which stalls the input if its register is full.
module string_to_integer_parser_core #(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_ch,
  input  wire logic        in_start_req,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [63:0]      out_value,
  output logic [15:0]      out_end_offset,
  output logic [5:0]       out_base_used,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [5:0]  cfg_base_setting
);

  s2i_pkg::item_t   in_item;
  s2i_pkg::item_t   item;
  logic             item_valid;
  logic             proc_ok;
  logic             step;
  logic             res_valid;
  s2i_pkg::result_t res;
  s2i_pkg::result_t out_res;

  assign cfg_ready         = 1'b1;
  assign in_item.ch        = in_ch;
  assign in_item.start_req = in_start_req;
  assign step              = item_valid & proc_ok;

  s2i_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_item    (in_item),
    .proc_ok    (proc_ok),
    .in_stall   (in_stall),
    .item_valid (item_valid),
    .item       (item)
  );

  s2i_parse #(
    .VALUE_BITS  (VALUE_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_valid & cfg_ready),
    .cfg_base  (cfg_base_setting),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  s2i_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .out_stall (out_stall),
    .proc_ok   (proc_ok),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_value      = out_res.value;
  assign out_end_offset = out_res.end_offset;
  assign out_base_used  = out_res.base_used;

  // The input only backs up behind a refused result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without output back-pressure");

  // A new result is only loaded by a word that was processed.
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(out_valid && out_stall)) |-> $past(step))
    else $error("result appeared without a processed word");

  // Base detection always resolves to a real radix before digits are taken.
  a_base_resolved: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_base_used != s2i_pkg::BASE_DETECT))
    else $error("result carries an unresolved base");

endmodule
`default_nettype wire

/* design/s2i_in_stage.sv */
`default_nettype none
module s2i_in_stage (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire s2i_pkg::item_t in_item,
  input  wire logic          proc_ok,
  output logic               in_stall,
  output logic               item_valid,
  output s2i_pkg::item_t     item
);

  logic           valid_r;
  logic           valid_nxt;
  logic           accept;
  s2i_pkg::item_t item_r;

  // The held word leaves whenever the parse stage may advance.
  assign in_stall  = valid_r & ~proc_ok;
  assign accept    = in_valid & ~in_stall;
  assign valid_nxt = accept | (valid_r & ~proc_ok);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

/* design/s2i_parse.sv */
`default_nettype none
module s2i_parse #(
  parameter int unsigned VALUE_BITS  = 64,
  parameter int unsigned OFFSET_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [s2i_pkg::BASE_BITS-1:0]     cfg_base,
  input  wire logic                              step,
  input  wire s2i_pkg::item_t                    item,
  output logic                                   res_valid,
  output s2i_pkg::result_t                       res
);

  localparam int unsigned BB = s2i_pkg::BASE_BITS;

  logic [BB-1:0]          base_setting_r;
  logic [2:0]             phase_r, phase_nxt, phase_w;
  logic [VALUE_BITS-1:0]  acc_r, acc_nxt, acc_w;
  logic                   neg_r, neg_nxt, neg_w;
  logic [BB-1:0]          base_r, base_nxt, base_w;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt, pos_w;

  logic                   active;
  logic                   lead_path;
  logic                   take;
  logic                   emit;
  logic [BB-1:0]          take_base;
  logic [BB-1:0]          digit;
  logic [VALUE_BITS-1:0]  signed_acc;
  logic [31:0]            pos_wide;

  always_comb begin
    // A start word restarts the parse before the character is looked at.
    phase_w = item.start_req ? s2i_pkg::PH_SPACE : phase_r;
    acc_w   = item.start_req ? '0 : acc_r;
    neg_w   = item.start_req ? 1'b0 : neg_r;
    base_w  = item.start_req ? base_setting_r : base_r;
    pos_w   = item.start_req ? '0 : pos_r;

    phase_nxt = phase_w;
    acc_nxt   = acc_w;
    neg_nxt   = neg_w;
    base_nxt  = base_w;
    active    = 1'b1;
    lead_path = 1'b0;
    take      = 1'b0;
    take_base = base_w;
    emit      = 1'b0;
    digit     = s2i_pkg::digit_of(item.ch);

    case (phase_w)
      s2i_pkg::PH_SPACE: begin
        if (s2i_pkg::is_space(item.ch)) begin
          phase_nxt = s2i_pkg::PH_SPACE;
        end else if (item.ch == s2i_pkg::CH_PLUS || item.ch == s2i_pkg::CH_MINUS) begin
          neg_nxt   = (item.ch == s2i_pkg::CH_MINUS);
          phase_nxt = s2i_pkg::PH_LEAD;
        end else begin
          lead_path = 1'b1;
        end
      end
      s2i_pkg::PH_LEAD: begin
        lead_path = 1'b1;
      end
      s2i_pkg::PH_ZERO: begin
        phase_nxt = s2i_pkg::PH_DIGITS;
        if (item.ch == s2i_pkg::CH_LO_X || item.ch == s2i_pkg::CH_UP_X) begin
          base_nxt = s2i_pkg::BASE_HEX;
        end else begin
          take_base = (base_w == s2i_pkg::BASE_DETECT) ? s2i_pkg::BASE_OCT : base_w;
          take      = 1'b1;
        end
      end
      s2i_pkg::PH_DIGITS: begin
        take = 1'b1;
      end
      default: begin
        active = 1'b0;
      end
    endcase

    if (lead_path) begin
      if ((base_w == s2i_pkg::BASE_DETECT || base_w == s2i_pkg::BASE_HEX) &&
          item.ch == s2i_pkg::CH_ZERO) begin
        phase_nxt = s2i_pkg::PH_ZERO;
      end else begin
        take_base = (base_w == s2i_pkg::BASE_DETECT) ? s2i_pkg::BASE_DEC : base_w;
        phase_nxt = s2i_pkg::PH_DIGITS;
        take      = 1'b1;
      end
    end

    if (take) begin
      base_nxt = take_base;
      if (digit >= take_base) begin
        emit      = 1'b1;
        phase_nxt = s2i_pkg::PH_DONE;
      end else begin
        acc_nxt = acc_w * VALUE_BITS'(take_base) + VALUE_BITS'(digit);
      end
    end

    // The position counts consumed characters and sticks at its top value.
    pos_nxt = pos_w;
    if (active && !emit && !(&pos_w)) begin
      pos_nxt = pos_w + 1'b1;
    end
  end

  assign signed_acc = neg_w ? (~acc_w + 1'b1) : acc_w;
  assign pos_wide   = 32'(pos_w);

  always_comb begin
    res.value      = s2i_pkg::VALUE_W'($signed(signed_acc));
    res.end_offset = (pos_wide > 32'h0000_FFFF) ? 16'hFFFF : pos_wide[15:0];
    res.base_used  = take_base;
  end

  assign res_valid = step & emit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_setting_r <= s2i_pkg::BASE_RESET;
      phase_r        <= s2i_pkg::PH_IDLE;
      acc_r          <= '0;
      neg_r          <= 1'b0;
      base_r         <= '0;
      pos_r          <= '0;
    end else begin
      if (cfg_we) begin
        base_setting_r <= cfg_base;
      end
      if (step) begin
        phase_r <= phase_nxt;
        acc_r   <= acc_nxt;
        neg_r   <= neg_nxt;
        base_r  <= base_nxt;
        pos_r   <= pos_nxt;
      end
    end
  end

endmodule
`default_nettype wire

/* design/s2i_out_stage.sv */
`default_nettype none
module s2i_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             res_valid,
  input  wire s2i_pkg::result_t res,
  input  wire logic             out_stall,
  output logic                  proc_ok,
  output logic                  out_valid,
  output s2i_pkg::result_t      out_res
);

  logic             valid_r;
  logic             valid_nxt;
  s2i_pkg::result_t res_r;

  // The register is free unless it holds a word that is being refused.
  assign proc_ok   = ~(valid_r & out_stall);
  assign valid_nxt = res_valid | (valid_r & out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule
`default_nettype wire

/* verif/tb.sv */
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_PCT      = 21;
  localparam int NO_WEIGHT     = 255;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SETTLE_CYCLES = 8;
  localparam int PHASE_ITEMS   = 170;
  localparam int HOLD_CYCLES   = 300;
  localparam int LONG_BLANKS   = 100;

  // Tracks the parse the way the block should, and keeps the values still owed.
  class parse_scoreboard;
    logic [s2i_pkg::BASE_BITS-1:0] base_reg;
    logic [2:0]                    parse_phase;
    logic [s2i_pkg::VALUE_W-1:0]   acc;
    bit                            neg;
    logic [s2i_pkg::BASE_BITS-1:0] act_base;
    logic [s2i_pkg::OFFSET_W-1:0]  pos;
    s2i_pkg::result_t              expected_parses[$];
    int                            errors;

    function new();
      base_reg    = s2i_pkg::BASE_RESET;
      parse_phase = s2i_pkg::PH_IDLE;
      acc         = '0;
      neg         = 1'b0;
      act_base    = '0;
      pos         = '0;
      errors      = 0;
    endfunction

    function void set_base(logic [s2i_pkg::BASE_BITS-1:0] b);
      base_reg = b;
    endfunction

    function int pending();
      return expected_parses.size();
    endfunction

    function bit is_blank(logic [s2i_pkg::CH_BITS-1:0] c);
      return c == s2i_pkg::CH_SP || c == s2i_pkg::CH_TAB || c == s2i_pkg::CH_LF ||
             c == s2i_pkg::CH_VT || c == s2i_pkg::CH_FF || c == s2i_pkg::CH_CR;
    endfunction

    function int weight_of(logic [s2i_pkg::CH_BITS-1:0] c);
      if (c >= s2i_pkg::CH_ZERO && c <= s2i_pkg::CH_NINE) return int'(c - s2i_pkg::CH_ZERO);
      if (c >= s2i_pkg::CH_LO_A && c <= s2i_pkg::CH_LO_Z)
        return int'(c - s2i_pkg::CH_LO_A) + 10;
      if (c >= s2i_pkg::CH_UP_A && c <= s2i_pkg::CH_UP_Z)
        return int'(c - s2i_pkg::CH_UP_A) + 10;
      return NO_WEIGHT;
    endfunction

    // Returns 1 when the character ends the parse and a value is owed.
    function bit take_digit(logic [s2i_pkg::CH_BITS-1:0] c);
      int               w;
      s2i_pkg::result_t r;
      w = weight_of(c);
      if (w == NO_WEIGHT || w >= int'(act_base)) begin
        r.value      = neg ? (64'd0 - acc) : acc;
        r.end_offset = pos;
        r.base_used  = act_base;
        expected_parses.push_back(r);
        parse_phase = s2i_pkg::PH_DONE;
        return 1'b1;
      end
      acc = acc * 64'(act_base) + 64'(w);
      return 1'b0;
    endfunction

    // Returns 1 when the word was acted on rather than ignored.
    function bit note_char(logic [s2i_pkg::CH_BITS-1:0] c, logic s);
      bit ended;
      ended = 1'b0;
      if (s) begin
        parse_phase = s2i_pkg::PH_SPACE;
        acc         = '0;
        neg         = 1'b0;
        act_base    = base_reg;
        pos         = '0;
      end
      if (parse_phase == s2i_pkg::PH_IDLE || parse_phase == s2i_pkg::PH_DONE) return 1'b0;
      case (parse_phase)
        s2i_pkg::PH_SPACE, s2i_pkg::PH_LEAD: begin
          if (parse_phase == s2i_pkg::PH_SPACE && is_blank(c)) begin
          end else if (parse_phase == s2i_pkg::PH_SPACE &&
                       (c == s2i_pkg::CH_PLUS || c == s2i_pkg::CH_MINUS)) begin
            neg         = (c == s2i_pkg::CH_MINUS);
            parse_phase = s2i_pkg::PH_LEAD;
          end else if ((act_base == s2i_pkg::BASE_DETECT || act_base == s2i_pkg::BASE_HEX) &&
                       c == s2i_pkg::CH_ZERO) begin
            parse_phase = s2i_pkg::PH_ZERO;
          end else begin
            if (act_base == s2i_pkg::BASE_DETECT) act_base = s2i_pkg::BASE_DEC;
            parse_phase = s2i_pkg::PH_DIGITS;
            ended = take_digit(c);
          end
        end
        s2i_pkg::PH_ZERO: begin
          if (c == s2i_pkg::CH_LO_X || c == s2i_pkg::CH_UP_X) begin
            act_base    = s2i_pkg::BASE_HEX;
            parse_phase = s2i_pkg::PH_DIGITS;
          end else begin
            if (act_base == s2i_pkg::BASE_DETECT) act_base = s2i_pkg::BASE_OCT;
            parse_phase = s2i_pkg::PH_DIGITS;
            ended = take_digit(c);
          end
        end
        default: ended = take_digit(c);
      endcase
      if (!ended && pos != {s2i_pkg::OFFSET_W{1'b1}}) pos++;
      return 1'b1;
    endfunction

    function void check_result(logic [s2i_pkg::VALUE_W-1:0] v,
                               logic [s2i_pkg::OFFSET_W-1:0] o,
                               logic [s2i_pkg::BASE_BITS-1:0] b);
      s2i_pkg::result_t e;
      if (expected_parses.size() == 0) begin
        $display("%0t: unexpected word, value %0d offset %0d base %0d",
                 $time, $signed(v), o, b);
        errors++;
        return;
      end
      e = expected_parses.pop_front();
      if (e.value !== v) begin
        $display("%0t: value expected %0d actual %0d", $time, $signed(e.value), $signed(v));
        errors++;
      end
      if (e.end_offset !== o) begin
        $display("%0t: end_offset expected %0d actual %0d", $time, e.end_offset, o);
        errors++;
      end
      if (e.base_used !== b) begin
        $display("%0t: base_used expected %0d actual %0d", $time, e.base_used, b);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [7:0]           in_ch;
  logic                 in_start_req;
  logic                 out_valid;
  logic                 out_stall;
  logic [63:0]          out_value;
  logic [15:0]          out_end_offset;
  logic [5:0]           out_base_used;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [5:0]           cfg_base_setting;

  parse_scoreboard sb;
  bit              calm;
  int              hold_left;
  int              items_taken;
  int              cycle_count;

  string_to_integer_parser_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_ch            (in_ch),
    .in_start_req     (in_start_req),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value        (out_value),
    .out_end_offset   (out_end_offset),
    .out_base_used    (out_base_used),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_base_setting (cfg_base_setting)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result side: a long hold takes priority over the random stalls.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall = 1'b1;
      hold_left--;
    end else begin
      out_stall = !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
      sb.check_result(out_value, out_end_offset, out_base_used);
  end

  // Entered just after a falling edge; returns just after a falling edge.
  task automatic send_char(input logic [7:0] c, input logic s);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid     = 1'b1;
    in_ch        = c;
    in_start_req = s;
    do @(posedge clk); while (in_stall !== 1'b0);
    if (sb.note_char(c, s)) items_taken++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_base(input logic [5:0] b);
    cfg_valid        = 1'b1;
    cfg_base_setting = b;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    sb.set_base(b);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [7:0] blank_char();
    case ($urandom_range(5))
      0: return s2i_pkg::CH_SP;
      1: return s2i_pkg::CH_TAB;
      2: return s2i_pkg::CH_LF;
      3: return s2i_pkg::CH_VT;
      4: return s2i_pkg::CH_FF;
      default: return s2i_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] digit_char(input int d);
    if (d < 10) return s2i_pkg::CH_ZERO + 8'(d);
    return ($urandom_range(1) ? s2i_pkg::CH_UP_A : s2i_pkg::CH_LO_A) + 8'(d - 10);
  endfunction

  // One plausible number: blanks, sign, prefix, digits and a closing character.
  task automatic send_number(input logic [5:0] b);
    logic [7:0] text[$];
    int         eff;
    int         kind;
    int         count;
    text = {};
    count = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
    repeat (count) text.push_back(blank_char());
    case ($urandom_range(3))
      0: text.push_back(s2i_pkg::CH_PLUS);
      1: text.push_back(s2i_pkg::CH_MINUS);
      default: ;
    endcase
    kind = $urandom_range(9);
    if (kind < 3) begin
      text.push_back(s2i_pkg::CH_ZERO);
      text.push_back($urandom_range(1) ? s2i_pkg::CH_UP_X : s2i_pkg::CH_LO_X);
    end else if (kind < 5) begin
      text.push_back(s2i_pkg::CH_ZERO);
    end
    eff = int'(b);
    if (b == s2i_pkg::BASE_DETECT) eff = (kind < 3) ? 16 : (kind < 5) ? 8 : 10;
    if (b == s2i_pkg::BASE_HEX && kind < 3) eff = 16;
    if (eff > 36) eff = 36;
    count = ($urandom_range(7) == 0) ? $urandom_range(12, 24) : $urandom_range(6);
    repeat (count)
      text.push_back(digit_char(($urandom_range(9) == 0) ? $urandom_range(35)
                                                          : $urandom_range(eff - 1)));
    case ($urandom_range(3))
      0: text.push_back(8'h00);
      1: text.push_back(8'($urandom_range(255)));
      2: text.push_back(s2i_pkg::CH_SP);
      default: text.push_back(8'($urandom_range(8'h21, 8'h2F)));
    endcase
    foreach (text[i]) send_char(text[i], i == 0);
    // Trailing characters after the end are ignored until the next start.
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic run_phase(input logic [5:0] b, input int items);
    int first;
    write_base(b);
    first = items_taken;
    while (items_taken - first < items) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 6))
          send_char(8'($urandom_range(255)), 1'($urandom_range(1)));
      end else begin
        send_number(b);
      end
    end
    wait_drained();
  endtask

  initial begin
    logic [5:0] phase_bases[10];
    logic [5:0] b;
    sb               = new();
    calm             = 1'b0;
    hold_left        = 0;
    items_taken      = 0;
    cycle_count      = 0;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_ch            = '0;
    in_start_req     = 1'b0;
    out_stall        = 1'b0;
    cfg_valid        = 1'b0;
    cfg_base_setting = '0;
    phase_bases = '{6'd0, 6'd16, 6'd63, 6'd1, 6'd8, 6'd36, 6'd37, 6'd2, 6'd0, 6'd10};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words with the base left at its reset value of ten.
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b1);
    send_char(s2i_pkg::CH_TAB, 1'b1);
    send_char(s2i_pkg::CH_VT, 1'b0);
    send_char(s2i_pkg::CH_MINUS, 1'b0);
    send_char(s2i_pkg::CH_NINE, 1'b0);
    send_char(s2i_pkg::CH_ZERO + 8'd2, 1'b0);
    send_char(s2i_pkg::CH_ZERO + 8'd3, 1'b0);
    send_char(s2i_pkg::CH_LO_Z, 1'b0);
    send_char(s2i_pkg::CH_UP_A, 1'b0);
    // A new start part-way through abandons the first number.
    send_char(s2i_pkg::CH_PLUS, 1'b1);
    send_char(s2i_pkg::CH_ZERO + 8'd4, 1'b0);
    send_char(s2i_pkg::CH_FF, 1'b1);
    send_char(s2i_pkg::CH_ZERO + 8'd7, 1'b0);
    send_char(s2i_pkg::CH_CR, 1'b0);
    send_char(s2i_pkg::CH_MINUS, 1'b1);
    send_char(8'h00, 1'b0);
    wait_drained();

    // Prefix detection: a bare 0x gives zero, a leading zero selects octal.
    write_base(s2i_pkg::BASE_DETECT);
    send_char(s2i_pkg::CH_ZERO, 1'b1);
    send_char(s2i_pkg::CH_LO_X, 1'b0);
    send_char(8'h00, 1'b0);
    send_char(s2i_pkg::CH_ZERO, 1'b1);
    send_char(s2i_pkg::CH_ZERO + 8'd1, 1'b0);
    send_char(s2i_pkg::CH_ZERO + 8'd7, 1'b0);
    send_char(s2i_pkg::CH_NINE, 1'b0);
    wait_drained();

    for (int p = 0; p < 10; p++) begin
      b = (p == 8) ? 6'($urandom_range(63)) : phase_bases[p];
      calm = (p == 4);
      if (p == 6) begin
        // Hold the result side so the block backs up onto its input.
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        @(negedge clk);
      end
      run_phase(b, PHASE_ITEMS);
    end

    // A long run of blanks gives a large offset before the digits.
    calm = 1'b1;
    send_char(s2i_pkg::CH_SP, 1'b1);
    repeat (LONG_BLANKS) send_char(blank_char(), 1'b0);
    send_char(s2i_pkg::CH_NINE, 1'b0);
    send_char(8'h00, 1'b0);
    wait_drained();

    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire
